// ----- rtl/mlprq_pkg.sv -----
// Shared types, codes and default sizes of the multilevel priority ready queue.
package mlprq_pkg;

  localparam int unsigned MAX_LEVELS_DEF  = 8;
  localparam int unsigned QUEUE_DEPTH_DEF = 16;
  localparam int unsigned ID_BITS_DEF     = 6;

  localparam logic [3:0] LEVEL_COUNT_RST = 4'd4;

  localparam logic CMD_ADD = 1'b0;
  localparam logic CMD_GET = 1'b1;

  localparam logic signed [3:0] LEVEL_EXPIRED = -4'sd1;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_EMPTY = 2'd1,
    ST_FULL  = 2'd2,
    ST_RANGE = 2'd3
  } status_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_PUSH,
    S_SCAN,
    S_READ,
    S_RESP
  } state_e;

  typedef enum logic [1:0] {
    QOP_NONE,
    QOP_PUSH,
    QOP_POP
  } qop_e;

  typedef struct packed {
    logic              command;
    logic [5:0]        process_id;
    logic signed [3:0] current_level;
    logic [3:0]        static_priority;
  } in_item_t;

  typedef struct packed {
    logic       granted;
    logic [5:0] chosen_id;
    logic [2:0] stored_level;
    status_e    status;
  } out_item_t;

  typedef struct packed {
    logic empty;
    logic full;
  } q_status_t;

endpackage

// ----- rtl/mlprq_qstore.sv -----
// FIFO pointer bank and id storage shared by all levels of both banks.
module mlprq_qstore import mlprq_pkg::*; #(
  parameter int unsigned MAX_LEVELS  = MAX_LEVELS_DEF,
  parameter int unsigned QUEUE_DEPTH = QUEUE_DEPTH_DEF,
  parameter int unsigned ID_BITS     = ID_BITS_DEF
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  qop_e                              op_i,
  input  logic [$clog2(2*MAX_LEVELS)-1:0]   qidx_i,
  input  logic [ID_BITS-1:0]                id_i,
  output q_status_t                         stat_o,
  output logic [ID_BITS-1:0]                rd_data_o
);

  localparam int unsigned QCNT   = 2 * MAX_LEVELS;
  localparam int unsigned PTR_W  = $clog2(QUEUE_DEPTH);
  localparam int unsigned FILL_W = $clog2(QUEUE_DEPTH + 1);
  localparam int unsigned SUM_W  = PTR_W + 1;
  localparam int unsigned ADDR_W = $clog2(QCNT * QUEUE_DEPTH);

  logic [PTR_W-1:0]  head_q [QCNT];
  logic [FILL_W-1:0] fill_q [QCNT];
  logic [ID_BITS-1:0] mem [QCNT * QUEUE_DEPTH];

  logic [PTR_W-1:0]  head_sel;
  logic [FILL_W-1:0] fill_sel;
  logic [SUM_W-1:0]  slot_sum;
  logic [PTR_W-1:0]  slot;
  logic [PTR_W-1:0]  head_inc;
  logic [ADDR_W-1:0] base;
  logic [ADDR_W-1:0] wr_addr;
  logic [ADDR_W-1:0] rd_addr;
  logic              do_push;
  logic              do_pop;

  assign head_sel = head_q[qidx_i];
  assign fill_sel = fill_q[qidx_i];

  assign stat_o.empty = (fill_sel == '0);
  assign stat_o.full  = (fill_sel == FILL_W'(QUEUE_DEPTH));

  assign do_push = (op_i == QOP_PUSH) && !stat_o.full;
  assign do_pop  = (op_i == QOP_POP) && !stat_o.empty;

  // Tail slot: head plus fill, wrapped once.
  always_comb begin
    slot_sum = SUM_W'(head_sel) + SUM_W'(fill_sel);
    if (slot_sum >= SUM_W'(QUEUE_DEPTH)) begin
      slot_sum = slot_sum - SUM_W'(QUEUE_DEPTH);
    end
    slot = slot_sum[PTR_W-1:0];
  end

  assign head_inc = (head_sel == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : head_sel + 1'b1;

  assign base    = ADDR_W'(qidx_i) * ADDR_W'(QUEUE_DEPTH);
  assign wr_addr = base + ADDR_W'(slot);
  assign rd_addr = base + ADDR_W'(head_sel);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < QCNT; i++) begin
        head_q[i] <= '0;
        fill_q[i] <= '0;
      end
    end else if (do_push) begin
      fill_q[qidx_i] <= fill_sel + 1'b1;
    end else if (do_pop) begin
      fill_q[qidx_i] <= fill_sel - 1'b1;
      head_q[qidx_i] <= head_inc;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem[wr_addr] <= id_i;
    end
    if (do_pop) begin
      rd_data_o <= mem[rd_addr];
    end
  end

endmodule

// ----- rtl/mlprq_fsm.sv -----
// Sequencer: add decode, one-level-per-cycle scan, bank swap and result register.
module mlprq_fsm import mlprq_pkg::*; #(
  parameter int unsigned MAX_LEVELS = MAX_LEVELS_DEF,
  parameter int unsigned ID_BITS    = ID_BITS_DEF
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic [$clog2(MAX_LEVELS+1)-1:0]   levels_i,
  input  logic                              in_valid_i,
  output logic                              in_stall_o,
  input  in_item_t                          in_item_i,
  output logic                              out_valid_o,
  input  logic                              out_stall_i,
  output out_item_t                         out_item_o,
  output qop_e                              q_op_o,
  output logic [$clog2(2*MAX_LEVELS)-1:0]   q_idx_o,
  output logic [ID_BITS-1:0]                q_id_o,
  input  q_status_t                         q_stat_i,
  input  logic [ID_BITS-1:0]                q_rd_data_i
);

  localparam int unsigned LVL_W  = (MAX_LEVELS > 1) ? $clog2(MAX_LEVELS) : 1;
  localparam int unsigned QIDX_W = $clog2(2 * MAX_LEVELS);

  state_e state_q, state_d;

  logic [LVL_W-1:0]   lvl_q, lvl_d;
  logic [QIDX_W-1:0]  qidx_q, qidx_d;
  logic               pass_q, pass_d;
  logic               bank_q, bank_d;
  logic [3:0]         tgt_q, tgt_d;
  logic [ID_BITS-1:0] id_q, id_d;
  out_item_t          res_q, res_d;
  logic               outv_q, outv_d;
  out_item_t          out_q, out_d;

  logic              accept;
  logic              load_out;
  logic              add_ok;
  logic              add_bank;
  logic [3:0]        add_tgt;
  logic [3:0]        sp_m1;
  logic [LVL_W-1:0]  top_lvl;
  logic              scan_last;

  function automatic logic [QIDX_W-1:0] qidx_of(input logic bank, input logic [LVL_W-1:0] lvl);
    qidx_of = bank ? QIDX_W'(MAX_LEVELS) + QIDX_W'(lvl) : QIDX_W'(lvl);
  endfunction

  assign in_stall_o  = (state_q != S_IDLE);
  assign accept      = in_valid_i && !in_stall_o;
  assign load_out    = (state_q == S_RESP) && (!outv_q || !out_stall_i);
  assign top_lvl     = LVL_W'(levels_i - 1'b1);
  assign scan_last   = (lvl_q == '0);
  assign out_valid_o = outv_q;
  assign out_item_o  = out_q;
  assign q_idx_o     = qidx_q;
  assign q_id_o      = id_q;

  // Add decode: active level, expired level from static priority, or out of range.
  always_comb begin
    sp_m1    = in_item_i.static_priority - 4'd1;
    add_ok   = 1'b0;
    add_bank = bank_q;
    add_tgt  = '0;
    if (!in_item_i.current_level[3]) begin
      add_tgt = 4'(in_item_i.current_level);
      add_ok  = 5'(add_tgt) < 5'(levels_i);
    end else if (in_item_i.current_level == LEVEL_EXPIRED) begin
      add_bank = !bank_q;
      add_tgt  = sp_m1;
      add_ok   = (in_item_i.static_priority != '0) && (5'(sp_m1) < 5'(levels_i));
    end
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE: begin
        if (accept) begin
          if (in_item_i.command == CMD_ADD) begin
            state_d = add_ok ? S_PUSH : S_RESP;
          end else begin
            state_d = (levels_i == '0) ? S_RESP : S_SCAN;
          end
        end
      end
      S_PUSH: state_d = S_RESP;
      S_SCAN: begin
        if (!q_stat_i.empty) begin
          state_d = S_READ;
        end else if (scan_last && pass_q) begin
          state_d = S_RESP;
        end
      end
      S_READ: state_d = S_RESP;
      S_RESP: begin
        if (load_out) begin
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_comb begin
    q_op_o = QOP_NONE;
    lvl_d  = lvl_q;
    qidx_d = qidx_q;
    pass_d = pass_q;
    bank_d = bank_q;
    tgt_d  = tgt_q;
    id_d   = id_q;
    res_d  = res_q;
    out_d  = out_q;
    outv_d = outv_q && out_stall_i;
    unique case (state_q)
      S_IDLE: begin
        if (accept) begin
          id_d  = ID_BITS'(in_item_i.process_id);
          res_d = '{granted: 1'b0, chosen_id: '0, stored_level: '0, status: ST_OK};
          if (in_item_i.command == CMD_ADD) begin
            tgt_d  = add_tgt;
            qidx_d = qidx_of(add_bank, LVL_W'(add_tgt));
            if (!add_ok) begin
              res_d.status = ST_RANGE;
            end
          end else begin
            lvl_d  = top_lvl;
            pass_d = 1'b0;
            qidx_d = qidx_of(bank_q, top_lvl);
            if (levels_i == '0) begin
              res_d.status = ST_EMPTY;
            end
          end
        end
      end
      S_PUSH: begin
        q_op_o = QOP_PUSH;
        if (q_stat_i.full) begin
          res_d.status = ST_FULL;
        end else begin
          res_d.stored_level = tgt_q[2:0];
        end
      end
      S_SCAN: begin
        if (!q_stat_i.empty) begin
          // Pop this level; if it was found in the expired bank, that bank becomes the active one.
          q_op_o = QOP_POP;
          if (pass_q) begin
            bank_d = !bank_q;
          end
        end else if (scan_last) begin
          if (pass_q) begin
            res_d.status = ST_EMPTY;
          end else begin
            pass_d = 1'b1;
            lvl_d  = top_lvl;
            qidx_d = qidx_of(!bank_q, top_lvl);
          end
        end else begin
          lvl_d  = lvl_q - 1'b1;
          qidx_d = qidx_q - 1'b1;
        end
      end
      S_READ: begin
        res_d.granted   = 1'b1;
        res_d.chosen_id = 6'(q_rd_data_i);
      end
      S_RESP: begin
        if (load_out) begin
          out_d  = res_q;
          outv_d = 1'b1;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      bank_q  <= 1'b0;
      pass_q  <= 1'b0;
      lvl_q   <= '0;
      qidx_q  <= '0;
      outv_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      bank_q  <= bank_d;
      pass_q  <= pass_d;
      lvl_q   <= lvl_d;
      qidx_q  <= qidx_d;
      outv_q  <= outv_d;
    end
  end

  always_ff @(posedge clk_i) begin
    tgt_q <= tgt_d;
    id_q  <= id_d;
    res_q <= res_d;
    out_q <= out_d;
  end

endmodule

// ----- rtl/multilevel_priority_ready_queue.sv -----
// Top level of the two-bank multilevel priority ready queue.
//
// Active/expired ready queue: each bank holds one FIFO of process ids per
// priority level. An add item with a level of 0 or more is queued in the
// active FIFO of that level; a level of -1 queues it in the expired FIFO at
// static priority minus one and reports that level back. A get item pops the
// head of the highest non-empty active level below level_count; if the whole
// active bank is empty but the expired bank is not, the banks swap and the
// pop is taken from the new active bank. Every item gives exactly one result.
// Timing: one item is worked at a time. An add in range goes through a push
// step before its result; an out-of-range add goes straight to its result.
// A get scans the FIFO fill counts, one level per cycle, first down the
// active bank and then down the expired bank; a hit adds a step for the
// registered id memory read. A get with level_count zero goes straight to
// its result. The next item can be taken in the cycle after its
// predecessor's result is loaded. A result waiting in the output register
// does not block the next accept; the result of that next item then waits
// in the sequencer and holds the input stalled until the output register
// is free. level_count is written through the cfg channel (always ready);
// the user must write it only while the block is idle, which the block
// itself does not enforce. Values above MAX_LEVELS act as MAX_LEVELS, and
// zero makes every add out of range and every get empty. The id memory
// needs no clearing after reset.
module multilevel_priority_ready_queue import mlprq_pkg::*; #(
  parameter int unsigned MAX_LEVELS  = MAX_LEVELS_DEF,
  parameter int unsigned QUEUE_DEPTH = QUEUE_DEPTH_DEF,
  parameter int unsigned ID_BITS     = ID_BITS_DEF
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_stall_o,
  input  in_item_t  in_item_i,
  output logic      out_valid_o,
  input  logic      out_stall_i,
  output out_item_t out_item_o,
  input  logic      cfg_valid_i,
  output logic      cfg_ready_o,
  input  logic [3:0] cfg_data_i
);

  localparam int unsigned LCNT_W = $clog2(MAX_LEVELS + 1);
  localparam int unsigned QIDX_W = $clog2(2 * MAX_LEVELS);

  logic [3:0]         level_count_q;
  logic [LCNT_W-1:0]  levels;
  qop_e               q_op;
  logic [QIDX_W-1:0]  q_idx;
  logic [ID_BITS-1:0] q_id;
  logic [ID_BITS-1:0] q_rd_data;
  q_status_t          q_stat;

  // The register write never waits.
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      level_count_q <= LEVEL_COUNT_RST;
    end else if (cfg_valid_i && cfg_ready_o) begin
      level_count_q <= cfg_data_i;
    end
  end

  // Saturate the level count to the levels actually built.
  assign levels = (5'(level_count_q) > 5'(MAX_LEVELS)) ? LCNT_W'(MAX_LEVELS)
                                                       : LCNT_W'(level_count_q);

  mlprq_fsm #(
    .MAX_LEVELS (MAX_LEVELS),
    .ID_BITS    (ID_BITS)
  ) u_fsm (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .levels_i    (levels),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_item_i   (in_item_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_item_o  (out_item_o),
    .q_op_o      (q_op),
    .q_idx_o     (q_idx),
    .q_id_o      (q_id),
    .q_stat_i    (q_stat),
    .q_rd_data_i (q_rd_data)
  );

  mlprq_qstore #(
    .MAX_LEVELS  (MAX_LEVELS),
    .QUEUE_DEPTH (QUEUE_DEPTH),
    .ID_BITS     (ID_BITS)
  ) u_qstore (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .op_i      (q_op),
    .qidx_i    (q_idx),
    .id_i      (q_id),
    .stat_o    (q_stat),
    .rd_data_o (q_rd_data)
  );

endmodule

// ----- rtl/mlprq_checker.sv -----
// Port-level checks of the ready queue, bound to the top level.
module mlprq_checker import mlprq_pkg::*; (
  input logic      clk_i,
  input logic      rst_ni,
  input logic      in_valid_i,
  input logic      in_stall_o,
  input logic      out_valid_o,
  input logic      out_stall_i,
  input out_item_t out_item_o
);

  // A stalled item holds.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(out_item_o))
    else $error("stalled result changed");

  // A grant always carries status ok.
  a_grant_ok: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_item_o.granted |-> out_item_o.status == ST_OK)
    else $error("grant with error status");

  // Failed items carry zero id and level.
  a_fail_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_item_o.status != ST_OK
      |-> !out_item_o.granted && out_item_o.chosen_id == '0 &&
          out_item_o.stored_level == '0)
    else $error("failed result with nonzero fields");

  // The block is busy right after taking an item.
  a_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> in_stall_o)
    else $error("accepted two items back to back");

endmodule

bind multilevel_priority_ready_queue mlprq_checker u_mlprq_checker (.*);
